### rtl/qea_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qea_pkg: shared types and constants
// Item formats, cell data, configuration codes and the fixed-point widths
// used by the quantized elementwise add/multiply/activation core.
// ============================================================================
package qea_pkg;

    localparam int DATA_W       = 8;
    localparam int NUM_FIELDS   = 4;
    localparam int MAX_OPERANDS = 4;
    localparam int NUM_CELLS    = (MAX_OPERANDS < NUM_FIELDS) ? MAX_OPERANDS : NUM_FIELDS;

    localparam int FP_W       = 6;
    localparam int KD_W       = FP_W + 1;
    localparam int IP_W       = 43;
    localparam int FR_W       = 41;
    localparam int PROD_W     = 30;
    localparam int MAG_W      = PROD_W - 1;
    localparam int EXP_W      = 9;
    localparam int SH_W       = EXP_W + 1;
    localparam int Q_W        = 56;
    localparam int V_W        = 64;
    localparam int LEAKY_W    = 11;
    localparam int FRAC       = 32;
    localparam int LEAKY_FRAC = 48;
    localparam int CLAMP_SH   = 52;
    localparam int SHIFTED_W  = MAG_W + CLAMP_SH;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;
    localparam int NUM_W      = 3;
    localparam int ACT_W      = 3;

    localparam logic signed [IP_W-1:0]    IP_LIMIT  = IP_W'(1) << 20;
    localparam logic signed [Q_W-1:0]     CLAMP_Q   = Q_W'(1) << CLAMP_SH;
    localparam logic [SHIFTED_W-1:0]      CLAMP_WIDE = SHIFTED_W'(1) << CLAMP_SH;
    localparam logic signed [Q_W-1:0]     SIX_Q     = Q_W'(6);
    localparam logic signed [LEAKY_W-1:0] LEAKY_NUM = LEAKY_W'(655);
    localparam logic signed [V_W-1:0]     HALF_Q32  = V_W'(1) << (FRAC - 1);
    localparam logic signed [V_W-1:0]     HALF_Q48  = V_W'(1) << (LEAKY_FRAC - 1);
    localparam logic signed [V_W-1:0]     SAT_HI    = V_W'(127);
    localparam logic signed [V_W-1:0]     SAT_LO    = -V_W'(128);

    localparam logic signed [FP_W-1:0] FP_MIN = -FP_W'(16);
    localparam logic signed [FP_W-1:0] FP_MAX = FP_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OPND = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FP0   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FP1   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FP2   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FP3   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FP   = 4'd7;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RELU  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PRELU = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LEAKY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELU6 = 3'd4;

    localparam logic [NUM_W-1:0] NUM_RESET = 3'd2;
    localparam logic [NUM_W-1:0] NUM_CELLS_N = NUM_W'(NUM_CELLS);

    typedef struct packed {
        logic signed [DATA_W-1:0] opnd_a;
        logic signed [DATA_W-1:0] opnd_b;
        logic signed [DATA_W-1:0] opnd_c;
        logic signed [DATA_W-1:0] opnd_d;
        logic                     last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     last_out;
    } out_item_t;

    typedef struct packed {
        logic signed [IP_W-1:0]   ip;
        logic signed [FR_W-1:0]   fr;
        logic signed [PROD_W-1:0] prod;
        logic signed [EXP_W-1:0]  expo;
    } acc_t;

    typedef struct packed {
        logic [NUM_FIELDS-1:0][DATA_W-1:0] opnd;
        logic                              last;
        acc_t                              acc;
    } cell_data_t;

    typedef struct packed {
        logic                   used;
        logic                   op_mul;
        logic signed [KD_W-1:0] k;
        logic signed [KD_W-1:0] d;
    } cell_cfg_t;

    typedef struct packed {
        logic                   op_mul;
        logic [ACT_W-1:0]       act_mode;
        logic signed [FP_W-1:0] out_fp;
    } post_cfg_t;

    function automatic logic signed [FP_W-1:0] fp_clamp(input logic [FP_W-1:0] r);
        logic signed [FP_W-1:0] v;
        v = $signed(r);
        if (v < FP_MIN)
        begin
            v = FP_MIN;
        end
        else if (v > FP_MAX)
        begin
            v = FP_MAX;
        end
        return v;
    endfunction

endpackage

### rtl/qea_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// qea_cell: one operand cell of the chain
// In a used cell, folds the head operand of the item into the running sum or
// product, then hands the item with its remaining operands to the next cell.
// ============================================================================
module qea_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  qea_pkg::cell_data_t up_data,
    input  qea_pkg::cell_cfg_t  cfg,
    output logic                dn_valid,
    input  logic                dn_ready,
    output qea_pkg::cell_data_t dn_data
);

    logic                                valid_reg;
    qea_pkg::cell_data_t                 data_reg;
    qea_pkg::cell_data_t                 data_next;
    logic signed [qea_pkg::DATA_W-1:0]   x;
    logic signed [qea_pkg::IP_W-1:0]     ip_term;
    logic signed [qea_pkg::FR_W-1:0]     fr_term;
    logic [4:0]                          fr_sh;
    logic signed [qea_pkg::PROD_W+qea_pkg::DATA_W-1:0] prod_full;

    always_comb
    begin
        x         = $signed(up_data.opnd[0]);
        ip_term   = qea_pkg::IP_W'(x) <<< cfg.k[5:0];
        fr_sh     = 5'(cfg.k + qea_pkg::KD_W'(32));
        fr_term   = qea_pkg::FR_W'(x) <<< fr_sh;
        prod_full = up_data.acc.prod * x;
        data_next = up_data;
        data_next.opnd = up_data.opnd >> qea_pkg::DATA_W;
        if (cfg.used)
        begin
            if (cfg.op_mul == qea_pkg::OP_MUL)
            begin
                data_next.acc.prod = prod_full[qea_pkg::PROD_W-1:0];
                data_next.acc.expo = up_data.acc.expo + qea_pkg::EXP_W'(cfg.d);
            end
            else if (!cfg.k[qea_pkg::KD_W-1])
            begin
                data_next.acc.ip = up_data.acc.ip + ip_term;
            end
            else
            begin
                data_next.acc.fr = up_data.acc.fr + fr_term;
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/qea_post.sv
`timescale 1ns / 1ps
// ============================================================================
// qea_post: output scaling, activation and rounding
// Forms the Q32 value from the chain result, applies the activation, then
// rounds half up and saturates to int8 in the output register.
// ============================================================================
module qea_post (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  qea_pkg::cell_data_t up_data,
    input  qea_pkg::post_cfg_t  cfg,
    output logic                res_valid,
    input  logic                res_ready,
    output qea_pkg::out_item_t  res
);

    logic                              va_reg, vb_reg, vc_reg;
    logic                              rdy_a, rdy_b, rdy_c;
    logic                              last_a_reg, last_b_reg;
    logic signed [qea_pkg::Q_W-1:0]    q_reg, q_next;
    logic signed [qea_pkg::V_W-1:0]    v_reg, v_next;
    logic                              leaky_reg, leaky_next;
    qea_pkg::out_item_t                res_reg, res_next;

    logic signed [qea_pkg::IP_W-1:0]   ip;
    logic                              prod_neg;
    logic [qea_pkg::PROD_W-1:0]        mag_full;
    logic [qea_pkg::MAG_W-1:0]         mag;
    logic signed [qea_pkg::SH_W-1:0]   sh;
    logic [qea_pkg::SHIFTED_W-1:0]     shifted;
    logic [qea_pkg::CLAMP_SH:0]        mq;
    logic [5:0]                        u_sh;
    logic signed [qea_pkg::Q_W-1:0]    u;
    logic signed [qea_pkg::Q_W+qea_pkg::LEAKY_W-1:0] leaky_full;
    logic signed [qea_pkg::V_W-1:0]    t;
    logic signed [qea_pkg::V_W-1:0]    r;

    assign rdy_c    = !vc_reg || res_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign up_ready = rdy_a;
    assign res_valid = vc_reg;
    assign res       = res_reg;

    always_comb
    begin
        ip       = up_data.acc.ip;
        prod_neg = up_data.acc.prod[qea_pkg::PROD_W-1];
        mag_full = prod_neg ? qea_pkg::PROD_W'(-up_data.acc.prod) : up_data.acc.prod;
        mag      = mag_full[qea_pkg::MAG_W-1:0];
        sh       = qea_pkg::SH_W'(up_data.acc.expo) + qea_pkg::SH_W'(qea_pkg::FRAC);
        if (sh[qea_pkg::SH_W-1])
        begin
            sh = '0;
        end
        shifted = qea_pkg::SHIFTED_W'(mag) << sh[5:0];
        if (mag == '0)
        begin
            mq = '0;
        end
        else if (sh >= qea_pkg::SH_W'(qea_pkg::CLAMP_SH) || shifted > qea_pkg::CLAMP_WIDE)
        begin
            mq = qea_pkg::CLAMP_WIDE[qea_pkg::CLAMP_SH:0];
        end
        else
        begin
            mq = shifted[qea_pkg::CLAMP_SH:0];
        end

        if (cfg.op_mul == qea_pkg::OP_MUL)
        begin
            q_next = prod_neg ? -qea_pkg::Q_W'(mq) : qea_pkg::Q_W'(mq);
        end
        else if (ip > qea_pkg::IP_LIMIT || ip < -qea_pkg::IP_LIMIT)
        begin
            q_next = ip[qea_pkg::IP_W-1] ? -qea_pkg::CLAMP_Q : qea_pkg::CLAMP_Q;
        end
        else
        begin
            q_next = (qea_pkg::Q_W'(ip) <<< qea_pkg::FRAC) + qea_pkg::Q_W'(up_data.acc.fr);
        end
    end

    always_comb
    begin
        u_sh       = 6'(qea_pkg::KD_W'(cfg.out_fp) + qea_pkg::KD_W'(qea_pkg::FRAC));
        u          = qea_pkg::SIX_Q << u_sh;
        leaky_full = q_reg * qea_pkg::LEAKY_NUM;
        leaky_next = 1'b0;
        v_next     = qea_pkg::V_W'(q_reg);
        case (cfg.act_mode)
            qea_pkg::ACT_RELU, qea_pkg::ACT_PRELU:
            begin
                if (q_reg < 0)
                begin
                    v_next = '0;
                end
            end
            qea_pkg::ACT_LEAKY:
            begin
                if (q_reg < 0)
                begin
                    v_next     = leaky_full[qea_pkg::V_W-1:0];
                    leaky_next = 1'b1;
                end
            end
            qea_pkg::ACT_RELU6:
            begin
                if (q_reg < 0)
                begin
                    v_next = '0;
                end
                else if (q_reg > u)
                begin
                    v_next = qea_pkg::V_W'(u);
                end
            end
            default:
            begin
                v_next = qea_pkg::V_W'(q_reg);
            end
        endcase
    end

    always_comb
    begin
        t = v_reg + (leaky_reg ? qea_pkg::HALF_Q48 : qea_pkg::HALF_Q32);
        r = leaky_reg ? (t >>> qea_pkg::LEAKY_FRAC) : (t >>> qea_pkg::FRAC);
        if (r > qea_pkg::SAT_HI)
        begin
            r = qea_pkg::SAT_HI;
        end
        else if (r < qea_pkg::SAT_LO)
        begin
            r = qea_pkg::SAT_LO;
        end
        res_next.result   = r[qea_pkg::DATA_W-1:0];
        res_next.last_out = last_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= up_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && rdy_a)
        begin
            q_reg      <= q_next;
            last_a_reg <= up_data.last;
        end
        if (va_reg && rdy_b)
        begin
            v_reg      <= v_next;
            leaky_reg  <= leaky_next;
            last_b_reg <= last_a_reg;
        end
        if (vb_reg && rdy_c)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### rtl/quantized_eltwise_add_mul_act_core.sv
`timescale 1ns / 1ps
// ============================================================================
// quantized_eltwise_add_mul_act_core: int8 elementwise add/multiply with
// activation
// Configuration registers, a chain of operand cells and the output stages.
// ============================================================================
// Each item passes one pipeline register per cell and then three output
// stages for scaling, activation and rounding.
// Throughput: one item per cycle unless res_ready holds the output back;
// every stage has its own handshake, so items keep entering while a
// result waits in the output register, until the earlier stages fill up.
// Reset clears the pipeline and loads the register reset values at once.
module quantized_eltwise_add_mul_act_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              elem_valid,
    output logic                              elem_ready,
    input  qea_pkg::in_item_t                 elem,
    output logic                              res_valid,
    input  logic                              res_ready,
    output qea_pkg::out_item_t                res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qea_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                                     op_mode_reg;
    logic [qea_pkg::ACT_W-1:0]                act_mode_reg;
    logic [qea_pkg::NUM_W-1:0]                num_reg;
    logic [qea_pkg::NUM_FIELDS-1:0][qea_pkg::FP_W-1:0] in_fp_reg;
    logic [qea_pkg::FP_W-1:0]                 out_fp_reg;

    logic signed [qea_pkg::FP_W-1:0]          fp [qea_pkg::NUM_FIELDS];
    logic signed [qea_pkg::FP_W-1:0]          o_fp;
    logic signed [qea_pkg::FP_W-1:0]          mx;
    logic [qea_pkg::NUM_W-1:0]                n_eff;
    qea_pkg::cell_cfg_t                       cell_cfg [qea_pkg::NUM_CELLS];
    qea_pkg::post_cfg_t                       post_cfg;

    logic                                     chain_valid [qea_pkg::NUM_CELLS+1];
    logic                                     chain_ready [qea_pkg::NUM_CELLS+1];
    qea_pkg::cell_data_t                      chain_data  [qea_pkg::NUM_CELLS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg  <= qea_pkg::OP_ADD;
            act_mode_reg <= qea_pkg::ACT_NONE;
            num_reg      <= qea_pkg::NUM_RESET;
            in_fp_reg    <= '0;
            out_fp_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qea_pkg::REG_OP_MODE:  op_mode_reg  <= cfg_data[0];
                qea_pkg::REG_ACT_MODE: act_mode_reg <= cfg_data[qea_pkg::ACT_W-1:0];
                qea_pkg::REG_NUM_OPND: num_reg      <= cfg_data[qea_pkg::NUM_W-1:0];
                qea_pkg::REG_IN_FP0:   in_fp_reg[0] <= cfg_data;
                qea_pkg::REG_IN_FP1:   in_fp_reg[1] <= cfg_data;
                qea_pkg::REG_IN_FP2:   in_fp_reg[2] <= cfg_data;
                qea_pkg::REG_IN_FP3:   in_fp_reg[3] <= cfg_data;
                qea_pkg::REG_OUT_FP:   out_fp_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        o_fp = qea_pkg::fp_clamp(out_fp_reg);
        if (num_reg == '0)
        begin
            n_eff = qea_pkg::NUM_W'(1);
        end
        else if (num_reg > qea_pkg::NUM_CELLS_N)
        begin
            n_eff = qea_pkg::NUM_CELLS_N;
        end
        else
        begin
            n_eff = num_reg;
        end
        for (int i = 0; i < qea_pkg::NUM_FIELDS; i++)
        begin
            fp[i] = qea_pkg::fp_clamp(in_fp_reg[i]);
        end
        mx = '0;
        for (int i = 0; i < qea_pkg::NUM_CELLS; i++)
        begin
            if (qea_pkg::NUM_W'(i) < n_eff && fp[i] > mx)
            begin
                mx = fp[i];
            end
        end
        for (int i = 0; i < qea_pkg::NUM_CELLS; i++)
        begin
            cell_cfg[i].used   = qea_pkg::NUM_W'(i) < n_eff;
            cell_cfg[i].op_mul = op_mode_reg;
            cell_cfg[i].k      = qea_pkg::KD_W'(o_fp) - qea_pkg::KD_W'(fp[i]);
            cell_cfg[i].d      = qea_pkg::KD_W'(mx) - qea_pkg::KD_W'(fp[i]);
        end
        post_cfg.op_mul   = op_mode_reg;
        post_cfg.act_mode = act_mode_reg;
        post_cfg.out_fp   = o_fp;
    end

    always_comb
    begin
        chain_valid[0]        = elem_valid;
        chain_data[0].opnd[0] = elem.opnd_a;
        chain_data[0].opnd[1] = elem.opnd_b;
        chain_data[0].opnd[2] = elem.opnd_c;
        chain_data[0].opnd[3] = elem.opnd_d;
        chain_data[0].last    = elem.last_in;
        chain_data[0].acc.ip  = '0;
        chain_data[0].acc.fr  = '0;
        chain_data[0].acc.prod = qea_pkg::PROD_W'(1);
        chain_data[0].acc.expo = qea_pkg::EXP_W'(o_fp) - qea_pkg::EXP_W'(mx);
    end

    assign elem_ready = chain_ready[0];

    for (genvar g = 0; g < qea_pkg::NUM_CELLS; g++)
    begin : g_cell
        qea_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_data  (chain_data[g]),
            .cfg      (cell_cfg[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_data  (chain_data[g+1])
        );
    end

    qea_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[qea_pkg::NUM_CELLS]),
        .up_ready  (chain_ready[qea_pkg::NUM_CELLS]),
        .up_data   (chain_data[qea_pkg::NUM_CELLS]),
        .cfg       (post_cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // An accepted item always lands in the first cell.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && elem_ready |=> chain_valid[1])
        else $error("accepted item did not reach the first cell");

    // A stalled first cell keeps its item.
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[1] && !chain_ready[1] |=> chain_valid[1] && $stable(chain_data[1]))
        else $error("first cell lost or changed a stalled item");

    // An empty first cell must take a new item.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !chain_valid[1] |-> elem_ready)
        else $error("input not ready while first cell is empty");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for quantized_eltwise_add_mul_act_core
// Drives int8 operand items through the valid/ready element channel under
// a series of register settings, predicts every output element in
// fixed point and compares each accepted result, in order, with the
// prediction. Corner settings come first, then random settings, most of them
// with random sender gaps, receiver stalls or both.
// ============================================================================
module testbench;

    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES    = 16;
    localparam int     RANDOM_PHASES   = 12;
    localparam int     ITEMS_PER_PHASE = 52;
    localparam int     Q_FRAC          = 32;
    localparam int     LEAKY_FRAC_BITS = 48;
    localparam longint LEAKY_SLOPE     = 655;
    localparam longint IP_BOUND        = longint'(1) << 20;
    localparam longint Q_CLAMP         = longint'(1) << 52;

    localparam logic [qea_pkg::ACT_W-1:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [qea_pkg::ACT_W-1:0] ACT_UNKNOWN_HI = 3'd7;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           elem_valid = 1'b0;
    logic                           elem_ready;
    qea_pkg::in_item_t              elem       = '0;
    logic                           res_valid;
    logic                           res_ready  = 1'b0;
    qea_pkg::out_item_t             res;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [qea_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [qea_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    qea_pkg::in_item_t  pending_elems[$];
    qea_pkg::out_item_t awaited_outputs[$];
    qea_pkg::out_item_t want;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    logic                                cur_op     = qea_pkg::OP_ADD;
    logic [qea_pkg::ACT_W-1:0]           cur_act    = qea_pkg::ACT_NONE;
    logic [qea_pkg::NUM_W-1:0]           cur_num    = 3'd2;
    logic [3:0][qea_pkg::FP_W-1:0]       cur_in_fp  = '0;
    logic [qea_pkg::FP_W-1:0]            cur_out_fp = '0;

    quantized_eltwise_add_mul_act_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .elem       (elem),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int fp_sat(input logic [qea_pkg::FP_W-1:0] raw);
        int v;
        v = $signed(raw);
        if (v < -16)
        begin
            v = -16;
        end
        if (v > 16)
        begin
            v = 16;
        end
        return v;
    endfunction

    function automatic qea_pkg::out_item_t calc_output_elem(input qea_pkg::in_item_t it);
        int                 n;
        int                 o;
        int                 mx;
        int                 k;
        int                 e;
        int                 sh;
        int                 fbits;
        int                 i;
        int                 fv[4];
        longint             xv[4];
        longint             ip;
        longint             fr;
        longint             q;
        longint             p;
        longint             u;
        longint             t;
        longint             r;
        longint unsigned    mag;
        qea_pkg::out_item_t y;
        n = cur_num;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > qea_pkg::NUM_CELLS)
        begin
            n = qea_pkg::NUM_CELLS;
        end
        o = fp_sat(cur_out_fp);
        xv[0] = $signed(it.opnd_a);
        xv[1] = $signed(it.opnd_b);
        xv[2] = $signed(it.opnd_c);
        xv[3] = $signed(it.opnd_d);
        mx = 0;
        for (i = 0; i < n; i++)
        begin
            fv[i] = fp_sat(cur_in_fp[i]);
            if (fv[i] > mx)
            begin
                mx = fv[i];
            end
        end
        q = 0;
        fbits = Q_FRAC;
        if (cur_op == qea_pkg::OP_ADD)
        begin
            ip = 0;
            fr = 0;
            for (i = 0; i < n; i++)
            begin
                k = o - fv[i];
                if (k >= 0)
                begin
                    ip += xv[i] * (longint'(1) << k);
                end
                else
                begin
                    fr += xv[i] * (longint'(1) << (k + Q_FRAC));
                end
            end
            if (ip > IP_BOUND || ip < -IP_BOUND)
            begin
                q = (ip < 0) ? -Q_CLAMP : Q_CLAMP;
            end
            else
            begin
                q = ip * (longint'(1) << Q_FRAC) + fr;
            end
        end
        else
        begin
            p = 1;
            e = o - mx;
            for (i = 0; i < n; i++)
            begin
                p *= xv[i];
                e += mx - fv[i];
            end
            if (p != 0)
            begin
                sh = e + Q_FRAC;
                if (sh < 0)
                begin
                    sh = 0;
                end
                mag = (p < 0) ? -p : p;
                if (sh >= 52 || mag > (Q_CLAMP >> sh))
                begin
                    mag = Q_CLAMP;
                end
                else
                begin
                    mag = mag << sh;
                end
                q = (p < 0) ? -longint'(mag) : longint'(mag);
            end
        end
        case (cur_act)
            qea_pkg::ACT_RELU, qea_pkg::ACT_PRELU:
            begin
                if (q < 0)
                begin
                    q = 0;
                end
            end
            qea_pkg::ACT_LEAKY:
            begin
                if (q < 0)
                begin
                    q = q * LEAKY_SLOPE;
                    fbits = LEAKY_FRAC_BITS;
                end
            end
            qea_pkg::ACT_RELU6:
            begin
                u = 6 * (longint'(1) << (o + Q_FRAC));
                if (q < 0)
                begin
                    q = 0;
                end
                if (q > u)
                begin
                    q = u;
                end
            end
            default:
            begin
            end
        endcase
        t = q + (longint'(1) << (fbits - 1));
        r = t >>> fbits;
        if (r > 127)
        begin
            r = 127;
        end
        if (r < -128)
        begin
            r = -128;
        end
        y.result = 8'(r);
        y.last_out = it.last_in;
        return y;
    endfunction

    function automatic logic [qea_pkg::DATA_W-1:0] pick_operand();
        logic [qea_pkg::DATA_W-1:0] v;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 4))
                0: v = 8'h80;
                1: v = 8'hFF;
                2: v = 8'h00;
                3: v = 8'h01;
                default: v = 8'h7F;
            endcase
        end
        else
        begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic push_elem(input logic [qea_pkg::DATA_W-1:0] a,
                             input logic [qea_pkg::DATA_W-1:0] b,
                             input logic [qea_pkg::DATA_W-1:0] c,
                             input logic [qea_pkg::DATA_W-1:0] d,
                             input logic last);
        qea_pkg::in_item_t it;
        it.opnd_a = a;
        it.opnd_b = b;
        it.opnd_c = c;
        it.opnd_d = d;
        it.last_in = last;
        pending_elems.push_back(it);
    endtask

    task automatic push_corner_elems();
        push_elem(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0);
        push_elem(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);
        push_elem(8'hFD, 8'h05, 8'hFF, 8'h01, 1'b0);
    endtask

    task automatic cfg_write(input logic [qea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qea_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            qea_pkg::REG_OP_MODE:  cur_op = data[0];
            qea_pkg::REG_ACT_MODE: cur_act = data[qea_pkg::ACT_W-1:0];
            qea_pkg::REG_NUM_OPND: cur_num = data[qea_pkg::NUM_W-1:0];
            qea_pkg::REG_IN_FP0:   cur_in_fp[0] = data;
            qea_pkg::REG_IN_FP1:   cur_in_fp[1] = data;
            qea_pkg::REG_IN_FP2:   cur_in_fp[2] = data;
            qea_pkg::REG_IN_FP3:   cur_in_fp[3] = data;
            qea_pkg::REG_OUT_FP:   cur_out_fp = data;
            default:
            begin
            end
        endcase
    endtask

    // Narrow registers get random upper data bits, which the block must ignore.
    task automatic program_regs(input logic op, input logic [qea_pkg::ACT_W-1:0] act,
                                input logic [qea_pkg::NUM_W-1:0] num,
                                input logic [3:0][qea_pkg::FP_W-1:0] fps,
                                input logic [qea_pkg::FP_W-1:0] ofp);
        logic [qea_pkg::CFG_DATA_W-1:0] junk;
        int i;
        junk = qea_pkg::CFG_DATA_W'($urandom());
        cfg_write(qea_pkg::REG_OP_MODE, {junk[5:1], op});
        cfg_write(qea_pkg::REG_ACT_MODE, {junk[2:0], act});
        cfg_write(qea_pkg::REG_NUM_OPND, {junk[5:3], num});
        for (i = 0; i < 4; i++)
        begin
            cfg_write(qea_pkg::CFG_IDX_W'(qea_pkg::REG_IN_FP0 + i), fps[i]);
        end
        cfg_write(qea_pkg::REG_OUT_FP, ofp);
        if ($urandom_range(0, 2) == 0)
        begin
            cfg_write(qea_pkg::CFG_IDX_W'($urandom_range(8, 15)),
                      qea_pkg::CFG_DATA_W'($urandom()));
        end
        cfg_valid <= 1'b0;
    endtask

    // Most settings keep the fix points close together so that results
    // land inside the int8 range instead of saturating.
    task automatic random_config();
        int                            b;
        int                            n;
        int                            mx;
        int                            sum_f;
        int                            o;
        int                            i;
        int                            fpv[4];
        logic                          op;
        logic [qea_pkg::ACT_W-1:0]     act;
        logic [qea_pkg::NUM_W-1:0]     num;
        logic [3:0][qea_pkg::FP_W-1:0] fps;
        logic [qea_pkg::FP_W-1:0]      ofp;
        op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8)
        begin
            act = qea_pkg::ACT_W'($urandom_range(qea_pkg::ACT_NONE, qea_pkg::ACT_RELU6));
        end
        else
        begin
            act = qea_pkg::ACT_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
        end
        if ($urandom_range(0, 9) < 8)
        begin
            num = qea_pkg::NUM_W'($urandom_range(1, 4));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: num = 3'd0;
                1: num = 3'd5;
                2: num = 3'd6;
                default: num = 3'd7;
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            for (i = 0; i < 4; i++)
            begin
                fps[i] = qea_pkg::FP_W'($urandom_range(0, 63));
            end
            ofp = qea_pkg::FP_W'($urandom_range(0, 63));
        end
        else
        begin
            b = int'($urandom_range(0, 12)) - 4;
            for (i = 0; i < 4; i++)
            begin
                fpv[i] = b + int'($urandom_range(0, 4)) - 2;
                fps[i] = qea_pkg::FP_W'(fpv[i]);
            end
            n = num;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > 4)
            begin
                n = 4;
            end
            mx = 0;
            sum_f = 0;
            for (i = 0; i < n; i++)
            begin
                sum_f += fpv[i];
                if (fpv[i] > mx)
                begin
                    mx = fpv[i];
                end
            end
            if (op == qea_pkg::OP_ADD)
            begin
                o = b + int'($urandom_range(0, 4)) - 3;
            end
            else
            begin
                o = 7 - 6 * n + sum_f - (n - 1) * mx + int'($urandom_range(0, 4)) - 2;
            end
            if (o < -16)
            begin
                o = -16;
            end
            if (o > 16)
            begin
                o = 16;
            end
            ofp = qea_pkg::FP_W'(o);
        end
        program_regs(op, act, num, fps, ofp);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        while (pending_elems.size() != 0 || elem_valid || awaited_outputs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            elem_valid <= 1'b0;
        end
        else if (!elem_valid || elem_ready)
        begin
            if (pending_elems.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                elem <= pending_elems.pop_front();
                elem_valid <= 1'b1;
            end
            else
            begin
                elem_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (elem_valid && elem_ready)
            begin
                awaited_outputs.push_back(calc_output_elem(elem));
            end
            if (res_valid && res_ready)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    $display("%0t: result %0d last %0b arrived with none outstanding",
                             $time, res.result, res.last_out);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (res.result !== want.result)
                    begin
                        $display("%0t: result mismatch: expected %0d, actual %0d",
                                 $time, want.result, res.result);
                        mismatch_count++;
                    end
                    if (res.last_out !== want.last_out)
                    begin
                        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                                 $time, want.last_out, res.last_out);
                        mismatch_count++;
                    end
                end
            end
            if ((elem_valid && elem_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** quantized_eltwise_add_mul_act_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int j;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the registers.
        push_corner_elems();
        drain_outputs();

        // A single operand at fix point 1 makes halves in both directions.
        program_regs(qea_pkg::OP_ADD, qea_pkg::ACT_NONE, 3'd1,
                     {6'd0, 6'd0, 6'd0, 6'd1}, 6'd0);
        push_corner_elems();
        drain_outputs();

        program_regs(qea_pkg::OP_ADD, qea_pkg::ACT_RELU6, 3'd4,
                     {6'd2, 6'd2, 6'd2, 6'd2}, 6'd2);
        push_corner_elems();
        drain_outputs();

        program_regs(qea_pkg::OP_ADD, qea_pkg::ACT_LEAKY, 3'd3,
                     {6'd0, 6'd0, 6'd0, 6'd0}, 6'd4);
        push_corner_elems();
        drain_outputs();

        // Out-of-range fix points and an integer sum beyond the clamp.
        program_regs(qea_pkg::OP_ADD, qea_pkg::ACT_RELU, 3'd4,
                     {6'h10, 6'h30, 6'h1F, 6'h20}, 6'h10);
        push_corner_elems();
        drain_outputs();

        // Zero operand count and an out-of-range output fix point.
        program_regs(qea_pkg::OP_MUL, qea_pkg::ACT_PRELU, 3'd0,
                     {6'd0, 6'd0, 6'd0, 6'h10}, 6'h1F);
        push_corner_elems();
        drain_outputs();

        program_regs(qea_pkg::OP_ADD, ACT_UNKNOWN_LO, 3'd7,
                     {6'd1, 6'd1, 6'd1, 6'd1}, 6'd0);
        push_corner_elems();
        drain_outputs();

        // Product scaled far past the clamp.
        program_regs(qea_pkg::OP_MUL, ACT_UNKNOWN_HI, 3'd4,
                     {6'h30, 6'h30, 6'h30, 6'h30}, 6'h10);
        push_corner_elems();
        drain_outputs();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct = 29;
                    stall_pct = 29;
                end
            endcase
            random_config();
            for (j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                push_elem(pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                          1'($urandom_range(0, 1)));
            end
            drain_outputs();
        end

        if (mismatch_count == 0)
        begin
            $display("** quantized_eltwise_add_mul_act_core: PASSED **");
        end
        else
        begin
            $display("** quantized_eltwise_add_mul_act_core: FAILED **");
        end
        $finish;
    end

endmodule
